// ----- sv/glb_container_validator_core_defines.svh -----
// Assertion macros shared by the GLB container validator RTL.
`ifndef GLB_CONTAINER_VALIDATOR_CORE_DEFINES_SVH
`define GLB_CONTAINER_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GLBCV_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GLBCV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/glbcv_pkg.sv -----
// Types and constants of the GLB container validator.
`default_nettype none

package glbcv_pkg;

    // Byte position counter, saturating at all ones
    localparam int unsigned CNT_W = 33;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Positions of the last byte of each header word
    localparam logic [CNT_W-1:0] POS_MAGIC    = 33'd3;
    localparam logic [CNT_W-1:0] POS_VERSION  = 33'd7;
    localparam logic [CNT_W-1:0] POS_LENGTH   = 33'd11;
    localparam logic [CNT_W-1:0] POS_JSON_LEN = 33'd15;
    localparam logic [CNT_W-1:0] POS_JSON_TYP = 33'd19;

    localparam logic [CNT_W-1:0] HDR_BYTES   = 33'd12;
    localparam logic [CNT_W-1:0] JSON_START  = 33'd20;
    localparam logic [CNT_W-1:0] CHUNK_HEAD  = 33'd8;
    localparam logic [CNT_W-1:0] BIN_LEN_OFS = 33'd3;
    localparam logic [CNT_W-1:0] BIN_TYP_OFS = 33'd7;
    localparam logic [CNT_W-1:0] ZERO_WINDOW = 33'd4;

    // Expected header and chunk words, little-endian
    localparam logic [31:0] HDR_MAGIC     = 32'h4654_6C67;
    localparam logic [31:0] GLB_VERSION   = 32'h0000_0002;
    localparam logic [31:0] TYPE_JSON     = 32'h4E4F_534A;
    localparam logic [31:0] TYPE_BIN      = 32'h004E_4942;
    localparam logic [7:0]  OPEN_BRACE    = 8'h7B;
    localparam logic [7:0]  ZERO_BYTE     = 8'h00;

    localparam int unsigned TDATA_IN_W  = 8;
    localparam int unsigned TDATA_OUT_W = 104;

    // Check outcome, first failing check wins
    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_MAGIC     = 4'd2,
        ST_VERSION   = 4'd3,
        ST_LENGTH    = 4'd4,
        ST_NOJSON    = 4'd5,
        ST_JSONTYPE  = 4'd6,
        ST_JSONALIGN = 4'd7,
        ST_JSONBOUND = 4'd8,
        ST_BRACE     = 4'd9,
        ST_BINTYPE   = 4'd10,
        ST_BINALIGN  = 4'd11,
        ST_BINBOUND  = 4'd12,
        ST_TRAILING  = 4'd13
    } t_status;

    // Parser state captured on the final byte of a file
    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic [31:0]      decl_len;
        logic [31:0]      json_len;
        logic [31:0]      bin_len;
        t_status          first_err;
        logic             brace_bad;
        logic             zero_seen;
        logic             bintype_bad;
    } t_snap;

    // Result request, packed lowest field last so it maps straight onto tdata
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] total_bytes;
        logic [31:0] bin_length;
        logic [31:0] json_length;
        logic        zero_pad_warning;
        logic        has_bin;
        t_status     status;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/glbcv_parser.sv -----
// Byte parser: input register, word assembly, position checks and end-of-file snapshot.
`default_nettype none

module glbcv_parser (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [glbcv_pkg::TDATA_IN_W-1:0]   i_s_tdata,
    input  wire                                i_s_tlast,
    output logic                               o_snap_vld,
    input  wire                                i_snap_ready,
    output glbcv_pkg::t_snap                   o_snap
);
    import glbcv_pkg::*;

    // Input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // File state
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_word;
    logic [31:0]      r_decl;
    logic [31:0]      r_jlen;
    logic [CNT_W-1:0] r_jend;
    logic [31:0]      r_blen;
    t_status          r_ferr;
    logic             r_brace_bad;
    logic             r_zero_seen;
    logic             r_bintype_bad;

    // Snapshot register
    logic  r_snap_vld;
    t_snap r_snap;

    logic             snap_free;
    logic             consume;
    logic             accept;
    logic             in_json;
    logic [CNT_W:0]   pos_ahead;
    logic [CNT_W-1:0] n_cnt;
    logic [31:0]      n_word;
    logic [31:0]      n_decl;
    logic [31:0]      n_jlen;
    logic [CNT_W-1:0] n_jend;
    logic [31:0]      n_blen;
    t_status          n_ferr;
    logic             n_brace_bad;
    logic             n_zero_seen;
    logic             n_bintype_bad;

    // Handshake: a non-final byte always drains, a final one needs the snapshot slot
    assign snap_free  = !r_snap_vld || i_snap_ready;
    assign consume    = r_in_vld && (!r_in_last || snap_free);
    assign o_s_tready = !r_in_vld || consume;
    assign accept     = i_s_tvalid && o_s_tready;

    // Per-byte checks against the current position
    assign in_json   = (r_cnt >= JSON_START);
    assign pos_ahead = {1'b0, r_cnt} + {1'b0, ZERO_WINDOW};

    always_comb begin
        n_word        = {r_in_byte, r_word[31:8]};
        n_cnt         = (r_cnt != CNT_MAX) ? r_cnt + 33'd1 : r_cnt;
        n_decl        = (r_cnt == POS_LENGTH) ? n_word : r_decl;
        n_jlen        = (r_cnt == POS_JSON_LEN) ? n_word : r_jlen;
        n_jend        = (r_cnt == POS_JSON_LEN) ? JSON_START + {1'b0, n_word} : r_jend;
        n_blen        = (in_json && r_cnt == r_jend + BIN_LEN_OFS) ? n_word : r_blen;
        n_brace_bad   = r_brace_bad || (r_cnt == JSON_START && r_in_byte != OPEN_BRACE);
        n_zero_seen   = r_zero_seen || (in_json && r_cnt < r_jend
                        && pos_ahead >= {1'b0, r_jend} && r_in_byte == ZERO_BYTE);
        n_bintype_bad = r_bintype_bad
                        || (in_json && r_cnt == r_jend + BIN_TYP_OFS && n_word != TYPE_BIN);
        // only the first of magic, version and JSON type is kept
        n_ferr = r_ferr;
        if (r_ferr == ST_OK) begin
            if (r_cnt == POS_MAGIC && n_word != HDR_MAGIC) begin
                n_ferr = ST_MAGIC;
            end else if (r_cnt == POS_VERSION && n_word != GLB_VERSION) begin
                n_ferr = ST_VERSION;
            end else if (r_cnt == POS_JSON_TYP && n_word != TYPE_JSON) begin
                n_ferr = ST_JSONTYPE;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (consume) begin
            r_in_vld <= 1'b0;
        end
        if (accept) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // File state: update per byte, back to the start after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (consume && r_in_last)) begin
            r_cnt         <= '0;
            r_word        <= '0;
            r_decl        <= '0;
            r_jlen        <= '0;
            r_jend        <= JSON_START;
            r_blen        <= '0;
            r_ferr        <= ST_OK;
            r_brace_bad   <= 1'b0;
            r_zero_seen   <= 1'b0;
            r_bintype_bad <= 1'b0;
        end else if (consume) begin
            r_cnt         <= n_cnt;
            r_word        <= n_word;
            r_decl        <= n_decl;
            r_jlen        <= n_jlen;
            r_jend        <= n_jend;
            r_blen        <= n_blen;
            r_ferr        <= n_ferr;
            r_brace_bad   <= n_brace_bad;
            r_zero_seen   <= n_zero_seen;
            r_bintype_bad <= n_bintype_bad;
        end
    end

    // Snapshot of the finished file for the checker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (consume && r_in_last) begin
            r_snap_vld <= 1'b1;
        end else if (i_snap_ready) begin
            r_snap_vld <= 1'b0;
        end
        if (consume && r_in_last) begin
            r_snap.total       <= n_cnt;
            r_snap.decl_len    <= n_decl;
            r_snap.json_len    <= n_jlen;
            r_snap.bin_len     <= n_blen;
            r_snap.first_err   <= n_ferr;
            r_snap.brace_bad   <= n_brace_bad;
            r_snap.zero_seen   <= n_zero_seen;
            r_snap.bintype_bad <= n_bintype_bad;
        end
    end

    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

endmodule

`default_nettype wire

// ----- sv/glbcv_check.sv -----
// File-level checks on the snapshot and the result register.
`default_nettype none

module glbcv_check (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_snap_vld,
    output logic                o_snap_ready,
    input  glbcv_pkg::t_snap    i_snap,
    output logic                o_res_vld,
    input  wire                 i_res_ready,
    output glbcv_pkg::t_result  o_res
);
    import glbcv_pkg::*;

    logic    r_out_vld;
    t_result r_out;

    logic             load;
    logic [CNT_W-1:0] json_end;
    logic [CNT_W:0]   total_w;
    logic [CNT_W:0]   bin_head_end;
    logic [CNT_W:0]   bin_end;
    t_status          st;
    logic             bin_present;
    logic             has_bin;
    t_result          n_res;

    assign o_snap_ready = !r_out_vld || i_res_ready;
    assign load         = i_snap_vld && o_snap_ready;

    // Chunk ends, wide enough never to wrap
    assign json_end     = JSON_START + {1'b0, i_snap.json_len};
    assign total_w      = {1'b0, i_snap.total};
    assign bin_head_end = {1'b0, json_end} + {1'b0, CHUNK_HEAD};
    assign bin_end      = bin_head_end + {2'b00, i_snap.bin_len};

    // Ordered checks, first failure wins
    always_comb begin
        st          = ST_OK;
        bin_present = 1'b0;
        has_bin     = 1'b0;
        if (i_snap.total < HDR_BYTES) begin
            st = ST_SHORT;
        end else if (i_snap.first_err == ST_MAGIC || i_snap.first_err == ST_VERSION) begin
            st = i_snap.first_err;
        end else if ({1'b0, i_snap.decl_len} != i_snap.total) begin
            st = ST_LENGTH;
        end else if (i_snap.total < JSON_START) begin
            st = ST_NOJSON;
        end else if (i_snap.first_err == ST_JSONTYPE) begin
            st = ST_JSONTYPE;
        end else if (i_snap.json_len[1:0] != 2'b00) begin
            st = ST_JSONALIGN;
        end else if (json_end > i_snap.total) begin
            st = ST_JSONBOUND;
        end else if (i_snap.json_len == 32'd0 || i_snap.brace_bad) begin
            st = ST_BRACE;
        end else begin
            // optional BIN chunk when a full chunk header fits
            if (bin_head_end <= total_w) begin
                bin_present = 1'b1;
                if (i_snap.bintype_bad) begin
                    st = ST_BINTYPE;
                end else if (i_snap.bin_len[1:0] != 2'b00) begin
                    st = ST_BINALIGN;
                end else if (bin_end > total_w) begin
                    st = ST_BINBOUND;
                end else begin
                    has_bin = 1'b1;
                end
            end
            if (st == ST_OK && (has_bin ? (bin_end != total_w) : (json_end != i_snap.total)))
            begin
                st = ST_TRAILING;
            end
        end
    end

    // Result fields
    always_comb begin
        n_res.pad              = '0;
        n_res.status           = st;
        n_res.has_bin          = has_bin;
        n_res.zero_pad_warning = (st == ST_OK || st >= ST_BINTYPE) && i_snap.zero_seen;
        n_res.json_length      = (st == ST_OK || st >= ST_JSONTYPE) ? i_snap.json_len : '0;
        n_res.bin_length       = bin_present ? i_snap.bin_len : '0;
        n_res.total_bytes      = i_snap.total[CNT_W-1] ? 32'hFFFF_FFFF
                                                       : i_snap.total[31:0];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_out_vld <= 1'b0;
        end
        if (load) begin
            r_out <= n_res;
        end
    end

    assign o_res_vld = r_out_vld;
    assign o_res     = r_out;

endmodule

`default_nettype wire

// ----- sv/glb_container_validator_core.sv -----
// Top level: GLB container validator, one file byte per request in, one result per file out.
// Throughput: one byte accepted every cycle, but a final byte waits while the snapshot slot is full;
// results leave through a registered output.
// Path of the final byte: input register, end-of-file snapshot, result register.
// Reset: synchronous active-low i_rst_n clears all valids and the parse state.
`default_nettype none
`include "glb_container_validator_core_defines.svh"

module glb_container_validator_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // slave side
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [glbcv_pkg::TDATA_IN_W-1:0]    i_s_tdata,  // [7:0] data_byte
    input  wire                                 i_s_tlast,  // last_byte
    // master side
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [glbcv_pkg::TDATA_OUT_W-1:0]   o_m_tdata   // [3:0] status, [4] has_bin,
                                                            // [5] zero_pad_warning,
                                                            // [37:6] json_length,
                                                            // [69:38] bin_length,
                                                            // [101:70] total_bytes, pad
);
    import glbcv_pkg::*;

    logic    w_snap_vld;
    logic    w_snap_ready;
    t_snap   w_snap;
    t_result w_res;

    glbcv_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .o_snap_vld   (w_snap_vld),
        .i_snap_ready (w_snap_ready),
        .o_snap       (w_snap)
    );

    glbcv_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_vld   (w_snap_vld),
        .o_snap_ready (w_snap_ready),
        .i_snap       (w_snap),
        .o_res_vld    (o_m_tvalid),
        .i_res_ready  (i_m_tready),
        .o_res        (w_res)
    );

    assign o_m_tdata = w_res;

    // A present BIN chunk means every check passed short of the trailing-byte check
    `GLBCV_ASSERT_IMPL(a_bin_clean, o_m_tvalid && w_res.has_bin,
        w_res.status == ST_OK || w_res.status == ST_TRAILING,
        "has_bin set on a file that failed before the trailing check")

    // Header-level failures never carry a JSON length
    `GLBCV_ASSERT_IMPL(a_json_len_gated,
        o_m_tvalid && w_res.status != ST_OK && w_res.status < ST_JSONTYPE,
        w_res.json_length == 32'd0, "json_length reported before the JSON header")

    // A snapshot waiting on a full output must not be dropped
    `GLBCV_ASSERT_NEXT(a_snap_held, w_snap_vld && !w_snap_ready, w_snap_vld,
        "end-of-file snapshot lost while the output stalled")

    // Status never leaves the defined code range
    `GLBCV_ASSERT_IMPL(a_status_range, o_m_tvalid, w_res.status <= ST_TRAILING,
        "status code out of range")

endmodule

`default_nettype wire

// ----- bench/glb_container_validator_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench: GLB files streamed byte by byte, results checked against a local predictor.
module glb_container_validator_core_tb;
    import glbcv_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 1000;
    localparam int unsigned BYTE_GOAL    = 1800;
    localparam int unsigned FILE_GOAL    = 36;
    localparam int unsigned CALM_FROM    = 1500;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned NROWS        = 22;

    // Ways a generated file departs from a well-formed one
    typedef enum logic [3:0] {
        FL_NONE, FL_SHORT, FL_MAGIC, FL_VERSION, FL_LENGTH, FL_NOJSON, FL_JSONTYPE,
        FL_JSONALIGN, FL_JSONBOUND, FL_BRACE, FL_EMPTYJSON, FL_BINTYPE, FL_BINALIGN,
        FL_BINBOUND, FL_TRAILING, FL_NOISE
    } t_flaw;

    // One directed file: shape, and the status where it is obvious
    typedef struct packed {
        t_flaw       flaw;
        logic [7:0]  jlen;
        logic [7:0]  blen;
        logic        bin;
        logic        zpad;
        logic [4:0]  cut;
        logic        typed;
        t_status     status;
    } t_row;

    localparam t_row DIRECTED [NROWS] = '{
        '{FL_NONE,      8'd8,  8'd0,  1'b0, 1'b0, 5'd0,  1'b1, ST_OK},
        '{FL_NONE,      8'd12, 8'd16, 1'b1, 1'b1, 5'd0,  1'b1, ST_OK},
        '{FL_NONE,      8'd4,  8'd0,  1'b1, 1'b0, 5'd0,  1'b1, ST_OK},
        '{FL_SHORT,     8'd8,  8'd0,  1'b0, 1'b0, 5'd1,  1'b1, ST_SHORT},
        '{FL_SHORT,     8'd8,  8'd0,  1'b0, 1'b0, 5'd11, 1'b1, ST_SHORT},
        '{FL_MAGIC,     8'd8,  8'd8,  1'b1, 1'b0, 5'd0,  1'b1, ST_MAGIC},
        '{FL_VERSION,   8'd8,  8'd0,  1'b0, 1'b0, 5'd0,  1'b1, ST_VERSION},
        '{FL_LENGTH,    8'd8,  8'd0,  1'b0, 1'b0, 5'd0,  1'b1, ST_LENGTH},
        '{FL_NOJSON,    8'd8,  8'd0,  1'b0, 1'b0, 5'd12, 1'b1, ST_NOJSON},
        '{FL_NOJSON,    8'd8,  8'd0,  1'b0, 1'b0, 5'd19, 1'b1, ST_NOJSON},
        '{FL_JSONTYPE,  8'd8,  8'd0,  1'b0, 1'b1, 5'd0,  1'b1, ST_JSONTYPE},
        '{FL_JSONALIGN, 8'd8,  8'd0,  1'b0, 1'b0, 5'd0,  1'b1, ST_JSONALIGN},
        '{FL_JSONBOUND, 8'd8,  8'd8,  1'b1, 1'b0, 5'd0,  1'b1, ST_JSONBOUND},
        '{FL_BRACE,     8'd8,  8'd0,  1'b0, 1'b0, 5'd0,  1'b1, ST_BRACE},
        '{FL_EMPTYJSON, 8'd0,  8'd8,  1'b1, 1'b0, 5'd0,  1'b1, ST_BRACE},
        '{FL_BINTYPE,   8'd8,  8'd8,  1'b1, 1'b1, 5'd0,  1'b1, ST_BINTYPE},
        '{FL_BINALIGN,  8'd8,  8'd8,  1'b1, 1'b0, 5'd0,  1'b1, ST_BINALIGN},
        '{FL_BINBOUND,  8'd8,  8'd8,  1'b1, 1'b0, 5'd0,  1'b1, ST_BINBOUND},
        '{FL_TRAILING,  8'd8,  8'd0,  1'b0, 1'b0, 5'd0,  1'b1, ST_TRAILING},
        '{FL_TRAILING,  8'd8,  8'd8,  1'b1, 1'b1, 5'd0,  1'b1, ST_TRAILING},
        '{FL_NOISE,     8'd0,  8'd0,  1'b0, 1'b0, 5'd0,  1'b0, ST_OK},
        '{FL_NONE,      8'd48, 8'd40, 1'b1, 1'b1, 5'd0,  1'b1, ST_OK}
    };

    // DUT ports, driven with known values from time zero
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic [TDATA_IN_W-1:0]  i_s_tdata  = '0;
    logic                   i_s_tlast  = 1'b0;
    logic                   i_m_tready = 1'b1;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [TDATA_OUT_W-1:0] o_m_tdata;

    // Predictor state
    logic [CNT_W-1:0] cnt_pos;
    logic [31:0]      word_sh;
    logic [31:0]      hdr_len;
    logic [31:0]      jlen_seen;
    logic [31:0]      blen_seen;
    t_status          early_err;
    logic             brace_bad;
    logic             zero_seen;
    logic             bintype_bad;

    // Expected verdicts, oldest first
    t_result    verdict_q [$];
    logic [7:0] file_bytes [$];

    t_status     row_status = ST_OK;
    bit          row_typed  = 1'b0;
    bit          calm       = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned files_sent = 0;
    int unsigned mismatches = 0;
    int          stall_left = 0;

    glb_container_validator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] data_byte
        .i_s_tlast  (i_s_tlast),   // last_byte
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // [3:0] status, [4] has_bin, [5] zero_pad_warning,
                                   // [37:6] json_length, [69:38] bin_length,
                                   // [101:70] total_bytes, pad
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor: back to the state of a fresh file
    task automatic glb_clear();
        cnt_pos     = '0;
        word_sh     = '0;
        hdr_len     = '0;
        jlen_seen   = '0;
        blen_seen   = '0;
        early_err   = ST_OK;
        brace_bad   = 1'b0;
        zero_seen   = 1'b0;
        bintype_bad = 1'b0;
    endtask

    // only the first header fault is kept
    task automatic note_err(input t_status code);
        if (early_err == ST_OK)
            early_err = code;
    endtask

    // Predictor: take one accepted byte, queue a verdict on the final one
    task automatic glb_absorb(input logic [7:0] b, input logic last);
        longint unsigned pos, jend, total, jl, off;
        t_status         st;
        logic            bin_seen, bin_ok;
        t_result         r;
        pos  = cnt_pos;
        jend = 64'd20 + jlen_seen;
        word_sh = {b, word_sh[31:8]};
        if (pos == 3 && word_sh != HDR_MAGIC)
            note_err(ST_MAGIC);
        if (pos == 7 && word_sh != GLB_VERSION)
            note_err(ST_VERSION);
        if (pos == 11)
            hdr_len = word_sh;
        if (pos == 15)
            jlen_seen = word_sh;
        if (pos == 19 && word_sh != TYPE_JSON)
            note_err(ST_JSONTYPE);
        if (pos == 20 && b != OPEN_BRACE)
            brace_bad = 1'b1;
        // zero byte among the last four JSON bytes
        if (pos >= 20 && pos < jend && pos + 4 >= jend && b == ZERO_BYTE)
            zero_seen = 1'b1;
        if (pos >= 20 && pos == jend + 3)
            blen_seen = word_sh;
        if (pos >= 20 && pos == jend + 7 && word_sh != TYPE_BIN)
            bintype_bad = 1'b1;
        if (cnt_pos != CNT_MAX)
            cnt_pos = cnt_pos + 1'b1;

        if (last) begin
            total    = cnt_pos;
            jl       = jlen_seen;
            off      = 64'd20 + jl;
            st       = ST_OK;
            bin_seen = 1'b0;
            bin_ok   = 1'b0;
            // checks in file order, first failure wins
            if (total < 12)
                st = ST_SHORT;
            else if (early_err == ST_MAGIC || early_err == ST_VERSION)
                st = early_err;
            else if ({32'd0, hdr_len} != total)
                st = ST_LENGTH;
            else if (total < 20)
                st = ST_NOJSON;
            else if (early_err == ST_JSONTYPE)
                st = ST_JSONTYPE;
            else if (jl[1:0] != 2'd0)
                st = ST_JSONALIGN;
            else if (off > total)
                st = ST_JSONBOUND;
            else if (jl == 0 || brace_bad)
                st = ST_BRACE;
            else begin
                if (off + 8 <= total) begin
                    bin_seen = 1'b1;
                    if (bintype_bad)
                        st = ST_BINTYPE;
                    else if (blen_seen[1:0] != 2'd0)
                        st = ST_BINALIGN;
                    else if (off + 8 + blen_seen > total)
                        st = ST_BINBOUND;
                    else begin
                        bin_ok = 1'b1;
                        off    = off + 8 + blen_seen;
                    end
                end
                if (st == ST_OK && off != total)
                    st = ST_TRAILING;
            end
            if (row_typed)
                st = row_status;

            r = '0;
            r.status           = st;
            r.has_bin          = bin_ok;
            r.zero_pad_warning = (st == ST_OK || st >= ST_BINTYPE) && zero_seen;
            r.json_length      = (st == ST_OK || st >= ST_JSONTYPE) ? jlen_seen : 32'd0;
            r.bin_length       = bin_seen ? blen_seen : 32'd0;
            r.total_bytes      = (total > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                  : total[31:0];
            verdict_q.insert(verdict_q.size(), r);
            glb_clear();
        end
    endtask

    // little-endian word into the file image
    task automatic put_word(input int at, input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            file_bytes[at + k] = w[8*k +: 8];
    endtask

    task automatic flip_bit(input int lo, input int hi);
        int at;
        at = $urandom_range(hi, lo);
        file_bytes[at] = file_bytes[at] ^ (8'd1 << $urandom_range(0, 7));
    endtask

    // Source: one byte request, with an occasional idle burst ahead of it
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk) i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        glb_absorb(b, last);
        bytes_sent++;
        calm = (bytes_sent >= CALM_FROM);
    endtask

    // Source falls silent until every verdict has come back
    task automatic hold_until_drained();
        @(negedge i_clk) i_s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Build a GLB image with the requested flaw and stream it
    task automatic play_file(input t_flaw flaw, input int jlen, input int blen,
                             input bit bin, input bit zpad, input int cut);
        logic [31:0] jfield, bfield;
        logic [7:0]  bv;
        int          bofs, n;
        file_bytes.delete();
        if (flaw == FL_NOISE) begin
            n = $urandom_range(1, 48);
            repeat (n) file_bytes.insert(file_bytes.size(), 8'($urandom));
        end else begin
            if (flaw == FL_EMPTYJSON)
                jlen = 0;
            if (flaw inside {FL_BINTYPE, FL_BINALIGN, FL_BINBOUND})
                bin = 1'b1;
            jfield = jlen;
            bfield = blen;
            // length words that break alignment or run past the end, wide values too
            case (flaw)
                FL_JSONALIGN: jfield = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                                   : jlen + $urandom_range(1, 3);
                FL_JSONBOUND: jfield = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFC : jlen + 256;
                FL_BINALIGN:  bfield = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                                   : blen + $urandom_range(1, 3);
                FL_BINBOUND:  bfield = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFC : blen + 256;
                default: ;
            endcase

            // header and JSON chunk head
            repeat (20) file_bytes.insert(file_bytes.size(), 8'h00);
            put_word(0, HDR_MAGIC);
            put_word(4, GLB_VERSION);
            put_word(12, jfield);
            put_word(16, TYPE_JSON);

            // JSON body: brace first, printable text, optional zero padding at the tail
            for (int k = 0; k < jlen; k++)
                file_bytes.insert(file_bytes.size(), 8'($urandom_range(32, 126)));
            if (jlen > 0)
                file_bytes[20] = OPEN_BRACE;
            if (zpad && jlen > 0) begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    file_bytes[19 + jlen - k] = ZERO_BYTE;
            end

            // BIN chunk with random payload
            bofs = 20 + jlen;
            if (bin) begin
                repeat (8 + blen) file_bytes.insert(file_bytes.size(), 8'($urandom));
                put_word(bofs, bfield);
                put_word(bofs + 4, TYPE_BIN);
            end

            case (flaw)
                FL_MAGIC:    flip_bit(0, 3);
                FL_VERSION:  flip_bit(4, 7);
                FL_JSONTYPE: flip_bit(16, 19);
                FL_BINTYPE:  flip_bit(bofs + 4, bofs + 7);
                FL_BRACE: begin
                    bv = 8'($urandom);
                    file_bytes[20] = (bv == OPEN_BRACE) ? ~OPEN_BRACE : bv;
                end
                FL_TRAILING: begin
                    n = $urandom_range(1, 7);
                    repeat (n) file_bytes.insert(file_bytes.size(), 8'($urandom));
                end
                FL_SHORT, FL_NOJSON: begin
                    while (file_bytes.size() > cut)
                        void'(file_bytes.pop_back());
                end
                default: ;
            endcase

            // declared length matches the image unless the flaw says otherwise
            if (file_bytes.size() >= 12)
                put_word(8, file_bytes.size());
            if (flaw == FL_LENGTH)
                flip_bit(8, 11);
        end

        for (int k = 0; k < file_bytes.size(); k++)
            push_byte(file_bytes[k], k == file_bytes.size() - 1);
        files_sent++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    // Sink: random stall bursts, none near the end
    always @(negedge i_clk) begin : sink_stalls
        if (calm || !i_rst_n)
            i_m_tready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_m_tready <= 1'b0;
        end else
            i_m_tready <= 1'b1;
    end

    // Result requests against the oldest verdict
    always @(posedge i_clk) begin : result_monitor
        t_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata);
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing outstanding, status %0d",
                             $realtime, got.status);
            end else begin
                want = verdict_q.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("has_bin", 32'(want.has_bin), 32'(got.has_bin));
                check_field("zero_pad_warning", 32'(want.zero_pad_warning),
                            32'(got.zero_pad_warning));
                check_field("json_length", want.json_length, got.json_length);
                check_field("bin_length", want.bin_length, got.bin_length);
                check_field("total_bytes", want.total_bytes, got.total_bytes);
            end
        end
    end

    // Watchdog on cycles with no request moving on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("glb_container_validator_core regression: fail");
        $finish;
    end

    // Stimulus: directed files, then random files, half of them well-formed
    initial begin : stimulus
        t_flaw fl;
        int    pick;
        glb_clear();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        for (int i = 0; i < NROWS; i++) begin
            row_typed  = DIRECTED[i].typed;
            row_status = DIRECTED[i].status;
            play_file(DIRECTED[i].flaw, DIRECTED[i].jlen, DIRECTED[i].blen,
                      DIRECTED[i].bin, DIRECTED[i].zpad, DIRECTED[i].cut);
        end
        row_typed = 1'b0;
        hold_until_drained();

        while (bytes_sent < BYTE_GOAL || files_sent < FILE_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                fl = FL_NONE;
            else if (pick < 90)
                fl = t_flaw'($urandom_range(FL_SHORT, FL_TRAILING));
            else
                fl = FL_NOISE;
            play_file(fl, 4 * $urandom_range(1, 12), 4 * $urandom_range(0, 10),
                      $urandom_range(0, 1), $urandom_range(0, 1),
                      (fl == FL_NOJSON) ? $urandom_range(12, 19) : $urandom_range(1, 11));
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("glb_container_validator_core regression: pass");
        else
            $display("glb_container_validator_core regression: fail");
        $finish;
    end

endmodule
